// File: hdl/vrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel ray traversal package
// Shared widths, codes and the command and status bundles that pass between
// the traversal controller and its datapath.
// ----------------------------------------------------------------------------
package vrt_pkg;

   // Fixed-point format and default grid size.
   localparam int FRAC_BITS           = 16;
   localparam int GRID_SIDE_DEFAULT   = 32;
   localparam int GRID_HEIGHT_DEFAULT = 32;

   // Small offset added to the travel distance before a sample is taken.
   localparam int NUDGE = ((1 << FRAC_BITS) + 500) / 1000;

   // Port widths.
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 72;
   localparam int STATUS_W   = 2;

   // Field widths.
   localparam int ORG_W  = 24;
   localparam int HEAD_W = 16;
   localparam int MD_W   = 16;
   localparam int CODE_W = 8;
   localparam int VOX_W  = 5;

   // Internal widths.
   localparam int SUM_W  = 32;
   localparam int ROOT_W = 32;
   localparam int REM_W  = 36;
   localparam int Q_W    = 18;
   localparam int STP_W  = 2 * FRAC_BITS + 1;
   localparam int LEN_W  = 48;
   localparam int DIV_DW = 48;
   localparam int DIV_VW = 33;
   localparam int T_W    = 25;
   localparam int PROD_W = T_W + Q_W;
   localparam int POS_W  = 29;
   localparam int K_W    = 11;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_TRACE = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NONE = 2'd0,
      STATUS_HIT  = 2'd1,
      STATUS_OUT  = 2'd2
   } status_type;

   // Division jobs run during ray setup.
   typedef enum logic [1:0] {
      JOB_DIR  = 2'd0,
      JOB_STEP = 2'd1,
      JOB_LEN  = 2'd2
   } job_type;

   typedef struct packed {
      logic       load;
      logic       write;
      logic       square;
      logic       root_start;
      logic       div_start;
      logic       div_store;
      job_type    job;
      logic [1:0] axis;
      logic       adjust;
      logic       mul;
      logic       pos;
      logic [1:0] pos_axis;
      logic       read;
      logic       advance;
      logic       dist_load;
      logic       count;
      logic       out_load;
      status_type status;
   } vrt_cmd_type;

   typedef struct packed {
      logic sum_zero;
      logic root_busy;
      logic div_busy;
      logic walk_on;
      logic outside;
      logic solid;
      logic moving_any;
   } vrt_stat_type;

endpackage

// File: hdl/voxel_ray_traversal_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel ray traversal
// Voxel grid store with a fixed-point 3D DDA ray walker.
//
// Channel   Direction  Contents
// req_*     in         tuser: cmd; tdata: voxel write fields and ray fields
// rsp_*     out        tuser: trace_status; tdata: hit point
//
// A voxel write is done on acceptance and the block is ready again at once.
// A trace first runs its setup, made of three squares, an integer square root
// and nine serial divisions, and then walks the grid one voxel step after
// another, the walk being bounded by max_distance/64 steps.
// Reset is synchronous and active high; the voxel store is not cleared.
// A finished result waits in its register while writes are still taken; a
// trace whose result slot is still full waits before loading it.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_top #(
   parameter int GRID_SIDE   = vrt_pkg::GRID_SIDE_DEFAULT,
   parameter int GRID_HEIGHT = vrt_pkg::GRID_HEIGHT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // cmd
   input  logic                           req_tuser,
   // voxel_x, voxel_y, voxel_z, voxel_code, origin_x, origin_y, origin_z,
   // heading_x, heading_y, heading_z, max_distance, one zero pad bit
   input  logic [vrt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // trace_status
   output logic [vrt_pkg::STATUS_W-1:0]   rsp_tuser,
   // hit_x, hit_y, hit_z
   output logic [vrt_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   vrt_pkg::vrt_cmd_type  cmd;
   vrt_pkg::vrt_stat_type stat;

   vrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_trace  (req_tuser == vrt_pkg::CMD_TRACE),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   vrt_dpath #(
      .GRID_SIDE   (GRID_SIDE),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_status (rsp_tuser),
      .rsp_data   (rsp_tdata)
   );

   // A result that is not a hit carries a zero hit point.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != vrt_pkg::STATUS_HIT) |-> rsp_tdata == '0)
      else $error("non-hit result with non-zero hit point");

   // A trace request occupies the block for the following cycle.
   a_trace_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == vrt_pkg::CMD_TRACE) |=> !req_tready)
      else $error("block ready right after taking a trace request");

   // A write request never stalls the request channel.
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == vrt_pkg::CMD_WRITE) |=> req_tready)
      else $error("block stalled after a write request");

endmodule

// File: hdl/vrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: hdl/vrt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vrt_div #(
   parameter int DIVIDEND_W = vrt_pkg::DIV_DW,
   parameter int DIVISOR_W  = vrt_pkg::DIV_VW
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic [DIVISOR_W:0]    rem_sh;
   logic                  ge;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge     = rem_sh >= {1'b0, dvs_ff};
      rem_in = ge ? DIVISOR_W'(rem_sh - {1'b0, dvs_ff}) : DIVISOR_W'(rem_sh);
      quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
   end

   // Control and data registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/vrt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traversal controller
// Sequences ray setup and the grid walk, and owns both handshakes.
// ----------------------------------------------------------------------------
module vrt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_trace,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  vrt_pkg::vrt_stat_type stat,
   output vrt_pkg::vrt_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT_START,
      ST_ROOT_WAIT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_ADJUST,
      ST_CHECK,
      ST_MUL,
      ST_BOUNDS,
      ST_CODE,
      ST_ADVANCE,
      ST_DIST,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           axis_ff, axis_in;
   logic [1:0]           phase_ff, phase_in;
   vrt_pkg::job_type     job_ff, job_in;
   vrt_pkg::status_type  status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;

   // Next state and commands to the datapath.
   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      phase_in  = phase_ff;
      job_in    = job_ff;
      status_in = status_ff;
      cmd          = '0;
      cmd.job      = job_ff;
      cmd.axis     = axis_ff;
      cmd.pos_axis = phase_ff - 2'd1;
      cmd.status   = status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_trace) begin
                  cmd.load  = 1'b1;
                  axis_in   = 2'd0;
                  status_in = vrt_pkg::STATUS_NONE;
                  state_in  = ST_SQUARE;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            if (axis_ff == 2'd2) begin
               axis_in  = 2'd0;
               state_in = ST_ROOT_START;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_ROOT_START: begin
            if (stat.sum_zero) begin
               status_in = vrt_pkg::STATUS_NONE;
               state_in  = ST_FINISH;
            end else begin
               cmd.root_start = 1'b1;
               state_in       = ST_ROOT_WAIT;
            end
         end
         ST_ROOT_WAIT: begin
            if (!stat.root_busy) begin
               job_in   = vrt_pkg::JOB_DIR;
               axis_in  = 2'd0;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (!stat.div_busy) begin
               cmd.div_store = 1'b1;
               state_in      = ST_DIV_START;
               if (axis_ff == 2'd2) begin
                  axis_in = 2'd0;
                  unique case (job_ff)
                     vrt_pkg::JOB_DIR:  job_in = vrt_pkg::JOB_STEP;
                     vrt_pkg::JOB_STEP: job_in = vrt_pkg::JOB_LEN;
                     default:           state_in = ST_ADJUST;
                  endcase
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
         end
         ST_ADJUST: begin
            cmd.adjust = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.walk_on) begin
               phase_in = 2'd0;
               state_in = ST_MUL;
            end else begin
               status_in = vrt_pkg::STATUS_NONE;
               state_in  = ST_FINISH;
            end
         end
         ST_MUL: begin
            // Multiply one axis and form the position of the previous one.
            cmd.axis = phase_ff;
            cmd.mul  = (phase_ff != 2'd3);
            cmd.pos  = (phase_ff != 2'd0);
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               state_in = ST_BOUNDS;
            end
         end
         ST_BOUNDS: begin
            if (stat.outside) begin
               status_in = vrt_pkg::STATUS_OUT;
               state_in  = ST_FINISH;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_CODE;
            end
         end
         ST_CODE: begin
            if (stat.solid) begin
               status_in = vrt_pkg::STATUS_HIT;
               state_in  = ST_FINISH;
            end else if (stat.moving_any) begin
               state_in = ST_ADVANCE;
            end else begin
               cmd.count = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = ST_DIST;
         end
         ST_DIST: begin
            cmd.dist_load = 1'b1;
            cmd.count     = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 2'd0;
         phase_ff     <= 2'd0;
         job_ff       <= vrt_pkg::JOB_DIR;
         status_ff    <= vrt_pkg::STATUS_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         phase_ff     <= phase_in;
         job_ff       <= job_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/vrt_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Traversal datapath
// Holds the ray, the normalizing root and divider, the walk registers, the
// voxel store and the result register.
// ----------------------------------------------------------------------------
module vrt_dpath #(
   parameter int GRID_SIDE   = vrt_pkg::GRID_SIDE_DEFAULT,
   parameter int GRID_HEIGHT = vrt_pkg::GRID_HEIGHT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [vrt_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  vrt_pkg::vrt_cmd_type             cmd,
   output vrt_pkg::vrt_stat_type            stat,
   output logic [vrt_pkg::STATUS_W-1:0]     rsp_status,
   output logic [vrt_pkg::RSP_DATA_W-1:0]   rsp_data
);

   localparam int F      = vrt_pkg::FRAC_BITS;
   localparam int XW     = $clog2(GRID_SIDE);
   localparam int YW     = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
   localparam int DEPTH  = GRID_SIDE * GRID_HEIGHT * GRID_SIDE;
   localparam int AW     = $clog2(DEPTH);
   localparam int ORG_W  = vrt_pkg::ORG_W;
   localparam int HEAD_W = vrt_pkg::HEAD_W;
   localparam int MD_W   = vrt_pkg::MD_W;
   localparam int POS_W  = vrt_pkg::POS_W;
   localparam int LEN_W  = vrt_pkg::LEN_W;
   localparam int PROD_W = vrt_pkg::PROD_W;
   localparam int T_W    = vrt_pkg::T_W;
   localparam int Q_W    = vrt_pkg::Q_W;
   localparam int STP_W  = vrt_pkg::STP_W;
   localparam int SUM_W  = vrt_pkg::SUM_W;
   localparam int ROOT_W = vrt_pkg::ROOT_W;
   localparam int REM_W  = vrt_pkg::REM_W;
   localparam int DIV_DW = vrt_pkg::DIV_DW;
   localparam int DIV_VW = vrt_pkg::DIV_VW;
   localparam int K_W    = vrt_pkg::K_W;
   localparam int CODE_W = vrt_pkg::CODE_W;
   localparam int VOX_W  = vrt_pkg::VOX_W;
   localparam int RCNT_W = $clog2(ROOT_W);
   localparam int CODE_SPACE = 32;
   localparam logic signed [POS_W-1:0] SIDE_LIM   = POS_W'(GRID_SIDE * (2 ** F));
   localparam logic signed [POS_W-1:0] HEIGHT_LIM = POS_W'(GRID_HEIGHT * (2 ** F));

   // Request fields.
   logic [VOX_W-1:0]  w_vx, w_vy, w_vz;
   logic [CODE_W-1:0] w_code;
   logic [ORG_W-1:0]  r_org [3];
   logic [HEAD_W-1:0] r_head [3];
   logic [MD_W-1:0]   r_md;

   assign w_vx      = req_tdata[4:0];
   assign w_vy      = req_tdata[9:5];
   assign w_vz      = req_tdata[14:10];
   assign w_code    = req_tdata[22:15];
   assign r_org[0]  = req_tdata[46:23];
   assign r_org[1]  = req_tdata[70:47];
   assign r_org[2]  = req_tdata[94:71];
   assign r_head[0] = req_tdata[110:95];
   assign r_head[1] = req_tdata[126:111];
   assign r_head[2] = req_tdata[142:127];
   assign r_md      = req_tdata[158:143];

   // Ray registers.
   logic signed [ORG_W-1:0] org_ff [3];
   logic [HEAD_W-1:0]       hmag_ff [3];
   logic                    hneg_ff [3];
   logic [MD_W-1:0]         md_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic [Q_W-1:0]          q_ff [3];
   logic [STP_W-1:0]        stp_ff [3];
   logic signed [LEN_W-1:0] len_ff [3];
   logic signed [LEN_W-1:0] d_ff;
   logic [K_W-1:0]          k_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic signed [POS_W-1:0] pos_ff [3];
   logic                    moving [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         moving[i] = (q_ff[i] != '0);
      end
   end

   // Shared multiplier: squares of the heading, then sample offsets.
   logic [T_W-1:0]    mul_a;
   logic [Q_W-1:0]    mul_b;
   logic [PROD_W-1:0] mul_p;

   always_comb begin
      if (cmd.square) begin
         mul_a = T_W'(hmag_ff[cmd.axis]);
         mul_b = Q_W'(hmag_ff[cmd.axis]);
      end else begin
         mul_a = T_W'(d_ff) + T_W'(vrt_pkg::NUDGE);
         mul_b = q_ff[cmd.axis];
      end
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Integer square root, two radicand bits per cycle.
   logic [ROOT_W-1:0] root_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [SUM_W-1:0]  src_ff;
   logic [RCNT_W-1:0] rcnt_ff;
   logic              rbusy_ff;
   logic [REM_W-1:0]  rem_sh, trial;

   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], src_ff[SUM_W-1 -: 2]};
      trial  = {REM_W'(root_ff) << 2} | REM_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rbusy_ff <= 1'b0;
         rcnt_ff  <= '0;
      end else if (cmd.root_start) begin
         rbusy_ff <= 1'b1;
         rcnt_ff  <= '0;
      end else if (rbusy_ff) begin
         rcnt_ff <= rcnt_ff + 1'b1;
         if (rcnt_ff == RCNT_W'(ROOT_W - 1)) begin
            rbusy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.root_start) begin
         root_ff <= '0;
         rem_ff  <= '0;
         src_ff  <= sum_ff;
      end else if (rbusy_ff) begin
         src_ff <= src_ff << 2;
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Divider operands for direction, reciprocal step and first boundary.
   logic [DIV_DW-1:0] div_num, div_quo;
   logic [DIV_VW-1:0] div_den;
   logic              div_busy;
   logic [F:0]        frac_num;
   logic [F-1:0]      frac;

   always_comb begin
      frac     = org_ff[cmd.axis][F-1:0];
      frac_num = hneg_ff[cmd.axis] ? {1'b0, frac} : ((F+1)'(1) << F) - {1'b0, frac};
      case (cmd.job)
         vrt_pkg::JOB_DIR: begin
            div_num = {hmag_ff[cmd.axis], {(DIV_DW-HEAD_W){1'b0}}}
                    + DIV_DW'(root_ff >> 1);
            div_den = DIV_VW'(root_ff);
         end
         vrt_pkg::JOB_STEP: begin
            div_num = DIV_DW'(1) << (2 * F);
            div_den = DIV_VW'(q_ff[cmd.axis]);
         end
         default: begin
            div_num = DIV_DW'(frac_num) << F;
            div_den = DIV_VW'(q_ff[cmd.axis]);
         end
      endcase
   end

   vrt_div #(
      .DIVIDEND_W (DIV_DW),
      .DIVISOR_W  (DIV_VW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // Axis choice: first moving axis with the smallest boundary distance.
   logic [1:0]              sel;
   logic                    found;
   logic signed [LEN_W-1:0] best;

   always_comb begin
      sel   = 2'd0;
      found = 1'b0;
      best  = '0;
      for (int i = 0; i < 3; i++) begin
         if (moving[i] && (!found || len_ff[i] < best)) begin
            sel   = 2'(i);
            found = 1'b1;
            best  = len_ff[i];
         end
      end
   end

   // Ray setup and walk registers.
   logic [POS_W-1:0] pmag;

   assign pmag = POS_W'(prod_ff >> F);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) begin
            org_ff[i]  <= $signed(r_org[i]);
            hneg_ff[i] <= r_head[i][HEAD_W-1];
            hmag_ff[i] <= r_head[i][HEAD_W-1] ? HEAD_W'(-r_head[i]) : r_head[i];
            q_ff[i]    <= '0;
         end
         md_ff  <= r_md;
         sum_ff <= '0;
      end
      if (cmd.square) begin
         sum_ff <= sum_ff + SUM_W'(mul_p);
      end
      if (cmd.div_store) begin
         case (cmd.job)
            vrt_pkg::JOB_DIR:  q_ff[cmd.axis]   <= Q_W'(div_quo);
            vrt_pkg::JOB_STEP: stp_ff[cmd.axis] <= STP_W'(div_quo);
            default:           len_ff[cmd.axis] <= $signed(LEN_W'(STP_W'(div_quo)));
         endcase
      end
      if (cmd.adjust) begin
         if (moving[0]) begin
            len_ff[0] <= len_ff[0] - $signed(LEN_W'(stp_ff[0]));
         end
         d_ff <= '0;
         k_ff <= '0;
      end
      if (cmd.mul) begin
         prod_ff <= mul_p;
      end
      if (cmd.pos) begin
         if (hneg_ff[cmd.pos_axis]) begin
            pos_ff[cmd.pos_axis] <= POS_W'(org_ff[cmd.pos_axis]) - $signed(pmag);
         end else begin
            pos_ff[cmd.pos_axis] <= POS_W'(org_ff[cmd.pos_axis]) + $signed(pmag);
         end
      end
      if (cmd.advance) begin
         len_ff[sel] <= len_ff[sel] + $signed(LEN_W'(stp_ff[sel]));
      end
      if (cmd.dist_load) begin
         d_ff <= best[LEN_W-1] ? '0 : best;
      end
      if (cmd.count) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   // Voxel store.
   logic [AW-1:0]     wr_addr, rd_addr;
   logic              wr_ok;
   logic [XW-1:0]     bx, bz;
   logic [YW-1:0]     by;
   logic [CODE_W-1:0] code;

   assign wr_ok   = (32'(w_vx) < 32'(GRID_SIDE)) && (32'(w_vy) < 32'(GRID_HEIGHT))
                 && (32'(w_vz) < 32'(GRID_SIDE));
   assign wr_addr = AW'((AW'(w_vx) * AW'(GRID_HEIGHT) + AW'(w_vy)) * AW'(GRID_SIDE)
                 + AW'(w_vz));
   assign bx      = pos_ff[0][F +: XW];
   assign by      = pos_ff[1][F +: YW];
   assign bz      = pos_ff[2][F +: XW];
   assign rd_addr = AW'((AW'(bx) * AW'(GRID_HEIGHT) + AW'(by)) * AW'(GRID_SIDE) + AW'(bz));

   vrt_ram #(
      .WIDTH (CODE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.write && wr_ok),
      .wr_addr (wr_addr),
      .wr_data (w_code),
      .rd_en   (cmd.read),
      .rd_addr (rd_addr),
      .rd_data (code)
   );

   // Status towards the controller.
   always_comb begin
      stat.sum_zero   = (sum_ff == '0);
      stat.root_busy  = rbusy_ff;
      stat.div_busy   = div_busy;
      stat.walk_on    = ({k_ff, 6'b0} < {1'b0, md_ff})
                     && (d_ff < $signed({{(LEN_W-MD_W-F+8){1'b0}}, md_ff, {(F-8){1'b0}}}));
      stat.outside    = pos_ff[0][POS_W-1] || pos_ff[1][POS_W-1] || pos_ff[2][POS_W-1]
                     || (pos_ff[0] >= SIDE_LIM) || (pos_ff[2] >= SIDE_LIM)
                     || (pos_ff[1] >= HEIGHT_LIM);
      stat.solid      = (code != CODE_W'(CODE_SPACE)) && (code != '0);
      stat.moving_any = moving[0] || moving[1] || moving[2];
   end

   // Result register: the hit point is reported only on a hit.
   logic [vrt_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [vrt_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.status;
         if (cmd.status == vrt_pkg::STATUS_HIT) begin
            rsp_data_ff <= {pos_ff[2][ORG_W-1:0], pos_ff[1][ORG_W-1:0],
                            pos_ff[0][ORG_W-1:0]};
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
